// ----- src/mf3w_pkg.sv -----
package mf3w_pkg;

    // Default and fixed sizes of the block.
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int PIX_W         = 8;
    localparam int CFGW_W        = 12;
    localparam int CFGH_W        = 16;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    // Number of taps in the 3x3 neighborhood and width of a rank within it.
    localparam int TAPS   = 9;
    localparam int RANK_W = 4;

    // Register indexes on the configuration port (address bit 2).
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFGW_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [CFGH_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

    // Input word: item kind and pixel.
    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic             frame_last;
    } out_word_t;

    // Configuration registers.
    typedef struct packed {
        logic [CFGW_W-1:0] image_width;
        logic [CFGH_W-1:0] image_height;
    } cfg_t;

    // One output position: its neighborhood, which taps lie inside the image, and
    // the end-of-frame flag. Tap index is row*3 + column, upper-left first.
    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] vals;
        logic [TAPS-1:0]            mask;
        logic                       frame_last;
    } job_t;

endpackage

// ----- src/mf3w_front.sv -----
module mf3w_front #(
    parameter int MAX_WIDTH = mf3w_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mf3w_pkg::cfg_t              cfg,
    input  logic                        s_valid,
    input  mf3w_pkg::in_word_t          s_data,
    output logic                        s_ready,
    input  logic [mf3w_pkg::QLVL_W-1:0] q_level,
    output logic                        push_valid,
    output mf3w_pkg::job_t              push_job
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = (EW > mf3w_pkg::CFGW_W) ? EW : mf3w_pkg::CFGW_W;
    localparam int PW    = $clog2(MAX_WIDTH + 3);
    localparam int PIX_W = mf3w_pkg::PIX_W;

    // Position counters and fill count.
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [15:0]      in_row_reg, in_row_next;
    logic [1:0]       in_slot_reg, in_slot_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [15:0]      out_row_reg, out_row_next;
    logic [1:0]       out_slot_reg, out_slot_next;
    logic [PW-1:0]    pend_reg, pend_next;

    // Second stage: read data arrives, write bypass is applied.
    logic                       b_valid_reg;
    logic [8:0]                 b_mask_reg;
    logic                       b_fl_reg;
    logic [2:0][1:0]            b_slot_reg;
    logic                       b_wen_reg;
    logic [1:0]                 b_wslot_reg;
    logic [COL_W-1:0]           b_waddr_reg;
    logic [PIX_W-1:0]           b_wpix_reg;
    logic [COL_W-1:0]           b_addra_reg;
    logic [COL_W-1:0]           b_addrb_reg;
    logic [2:0][PIX_W-1:0]      prev_col_reg;

    logic [XW-1:0]    w_ext;
    logic [EW-1:0]    w_eff;
    logic [EW:0]      w_cmp;
    logic [15:0]      h_eff;
    logic [EW:0]      in_col_p1;
    logic [EW:0]      out_col_p1;
    logic [EW:0]      out_col_x;
    logic [16:0]      in_row_p1;
    logic [16:0]      out_row_p1;
    logic [PW:0]      pend_p1;
    logic             acc;
    logic             is_pix;
    logic             wen;
    logic             emit;
    logic [8:0]       mask_c;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic             fl_c;
    logic [COL_W-1:0] addr_a;
    logic [COL_W-1:0] addr_b;
    logic [3:0][PIX_W-1:0] rda;
    logic [3:0][PIX_W-1:0] rdb;
    logic [2:0][PIX_W-1:0] cur_a;
    logic [2:0][PIX_W-1:0] cur_b;

    // Effective frame size: width clamped to 1..MAX_WIDTH, height 0 taken as 1.
    assign w_ext = XW'(cfg.image_width);
    always_comb begin
        priority if (w_ext == '0) begin
            w_eff = EW'(1);
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(w_ext);
        end
    end
    assign w_cmp = {1'b0, w_eff};
    assign h_eff = (cfg.image_height == '0) ? 16'd1 : cfg.image_height;

    assign in_col_p1  = (EW+1)'(in_col_reg) + (EW+1)'(1);
    assign out_col_x  = (EW+1)'(out_col_reg);
    assign out_col_p1 = out_col_x + (EW+1)'(1);
    assign in_row_p1  = {1'b0, in_row_reg} + 17'd1;
    assign out_row_p1 = {1'b0, out_row_reg} + 17'd1;
    assign pend_p1    = (PW+1)'(pend_reg) + (PW+1)'(1);

    // Room in the queue for every word that can still be in flight.
    assign s_ready = ((mf3w_pkg::QLVL_W+1)'(q_level) + (mf3w_pkg::QLVL_W+1)'(b_valid_reg))
                     < (mf3w_pkg::QLVL_W+1)'(mf3w_pkg::QUEUE_DEPTH);

    // Classify the accepted word: a pixel emits once the fill count reaches
    // width+2, a drain tick emits only at a frame boundary with output pending.
    assign acc    = s_valid && s_ready;
    assign is_pix = !s_data.func;
    assign wen    = acc && is_pix;
    always_comb begin
        if (is_pix) begin
            emit = acc && (pend_p1 >= ((PW+1)'(w_eff) + (PW+1)'(2)));
        end else begin
            emit = acc && (in_row_reg == '0) && (in_col_reg == '0) && (pend_reg != '0);
        end
    end

    // Counter updates.
    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        pend_next     = pend_reg;
        if (wen) begin
            if (in_col_p1 >= w_cmp) begin
                in_col_next  = '0;
                in_slot_next = in_slot_reg + 2'd1;
                in_row_next  = (in_row_p1 >= {1'b0, h_eff}) ? 16'd0 : in_row_p1[15:0];
            end else begin
                in_col_next = in_col_p1[COL_W-1:0];
            end
        end
        if (emit) begin
            if (out_col_p1 >= w_cmp) begin
                out_col_next  = '0;
                out_slot_next = out_slot_reg + 2'd1;
                out_row_next  = (out_row_p1 >= {1'b0, h_eff}) ? 16'd0 : out_row_p1[15:0];
            end else begin
                out_col_next = out_col_p1[COL_W-1:0];
            end
        end
        if (wen && !emit) begin
            pend_next = pend_p1[PW-1:0];
        end else if (!wen && emit) begin
            pend_next = pend_reg - PW'(1);
        end
    end

    // Which taps of the output position lie inside the image.
    always_comb begin
        row_ok[0] = (out_row_reg != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = (out_row_p1 < {1'b0, h_eff});
        col_ok[0] = (out_col_reg != '0) && (out_col_x <= w_cmp);
        col_ok[1] = (out_col_x < w_cmp);
        col_ok[2] = (out_col_p1 < w_cmp);
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                mask_c[r*3 + k] = row_ok[r] && col_ok[k];
            end
        end
        fl_c = (out_row_p1 >= {1'b0, h_eff}) && (out_col_p1 >= w_cmp);
    end

    assign addr_a = out_col_reg;
    assign addr_b = out_col_p1[COL_W-1:0];

    // Four row banks: one written by the input, all read at columns c and c+1.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PIX_W-1:0] bank_mem [MAX_WIDTH];
        always_ff @(posedge aclk) begin
            if (wen && (in_slot_reg == 2'(b))) begin
                bank_mem[in_col_reg] <= s_data.pixel;
            end
            rda[b] <= bank_mem[addr_a];
            rdb[b] <= bank_mem[addr_b];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            pend_reg     <= '0;
            b_valid_reg  <= 1'b0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            pend_reg     <= pend_next;
            b_valid_reg  <= emit;
        end
    end

    // Second-stage payload.
    always_ff @(posedge aclk) begin
        b_mask_reg    <= mask_c;
        b_fl_reg      <= fl_c;
        b_slot_reg[0] <= out_slot_reg + 2'd3;
        b_slot_reg[1] <= out_slot_reg;
        b_slot_reg[2] <= out_slot_reg + 2'd1;
        b_wen_reg     <= wen;
        b_wslot_reg   <= in_slot_reg;
        b_waddr_reg   <= in_col_reg;
        b_wpix_reg    <= s_data.pixel;
        b_addra_reg   <= addr_a;
        b_addrb_reg   <= addr_b;
        if (b_valid_reg) begin
            prev_col_reg <= cur_a;
        end
    end

    // Pick the three rows from the banks; the pixel written in the same cycle
    // as the read is forwarded.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (b_wen_reg && (b_wslot_reg == b_slot_reg[r]) && (b_waddr_reg == b_addra_reg)) begin
                cur_a[r] = b_wpix_reg;
            end else begin
                cur_a[r] = rda[b_slot_reg[r]];
            end
            if (b_wen_reg && (b_wslot_reg == b_slot_reg[r]) && (b_waddr_reg == b_addrb_reg)) begin
                cur_b[r] = b_wpix_reg;
            end else begin
                cur_b[r] = rdb[b_slot_reg[r]];
            end
        end
    end

    // The left column is the center column of the previous output position.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            push_job.vals[r*3 + 0] = prev_col_reg[r];
            push_job.vals[r*3 + 1] = cur_a[r];
            push_job.vals[r*3 + 2] = cur_b[r];
        end
        push_job.mask       = b_mask_reg;
        push_job.frame_last = b_fl_reg;
    end
    assign push_valid = b_valid_reg;

    // The fill count never passes one row plus one pixel.
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PW'(MAX_WIDTH + 1))
        else $error("fill count out of range");

    // A word is only accepted when the queue can take what is in flight.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |-> ((mf3w_pkg::QLVL_W+1)'(q_level) + (mf3w_pkg::QLVL_W+1)'(b_valid_reg))
                < (mf3w_pkg::QLVL_W+1)'(mf3w_pkg::QUEUE_DEPTH))
        else $error("accepted without queue room");

endmodule

// ----- src/mf3w_queue.sv -----
module mf3w_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push_valid,
    input  mf3w_pkg::job_t              push_job,
    input  logic                        pop,
    output logic                        q_valid,
    output mf3w_pkg::job_t              q_job,
    output logic [mf3w_pkg::QLVL_W-1:0] q_level
);

    mf3w_pkg::job_t                    slot_reg [mf3w_pkg::QUEUE_DEPTH];
    logic [mf3w_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mf3w_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mf3w_pkg::QLVL_W-1:0]       level_reg, level_next;
    logic                              do_pop;

    assign q_valid = (level_reg != '0);
    assign q_job   = slot_reg[rd_ptr_reg];
    assign q_level = level_reg;
    assign do_pop  = pop && q_valid;

    // Pointer and level updates.
    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push_valid && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push_valid && do_pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // A push never lands in a full queue.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (level_reg != mf3w_pkg::QLVL_W'(mf3w_pkg::QUEUE_DEPTH)) || do_pop)
        else $error("push into full queue");

endmodule

// ----- src/mf3w_back.sv -----
module mf3w_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  mf3w_pkg::job_t      q_job,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output mf3w_pkg::out_word_t m_data
);

    localparam int PIX_W  = mf3w_pkg::PIX_W;
    localparam int TAPS   = mf3w_pkg::TAPS;
    localparam int RANK_W = mf3w_pkg::RANK_W;

    // Rank stage.
    logic                              s1_valid_reg, s1_valid_next;
    logic [TAPS-1:0][PIX_W-1:0]        s1_vals_reg;
    logic [TAPS-1:0]                   s1_mask_reg;
    logic                              s1_fl_reg;
    logic [TAPS-1:0][RANK_W-1:0]       s1_rank_reg;
    logic [RANK_W-1:0]                 s1_n_reg;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    mf3w_pkg::out_word_t m_data_reg;

    logic [TAPS-1:0][RANK_W-1:0] rank_c;
    logic [RANK_W-1:0]           n_c;
    logic                        out_adv;
    logic                        s1_adv;
    logic [RANK_W-1:0]           lo_k;
    logic [RANK_W-1:0]           hi_k;
    logic [TAPS-1:0]             lo_match;
    logic [TAPS-1:0]             hi_match;
    logic [PIX_W-1:0]            lo_val;
    logic [PIX_W-1:0]            hi_val;
    logic [PIX_W:0]              mid_sum;
    logic [PIX_W-1:0]            filt_c;

    // Stage enables: each stage moves when the one after it is free or moving.
    assign out_adv = !m_valid_reg || m_ready;
    assign s1_adv  = s1_valid_reg && out_adv;
    assign pop     = q_valid && (!s1_valid_reg || out_adv);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (pop) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Rank of each valid tap among the valid taps; ties go by tap index.
    always_comb begin
        n_c = '0;
        for (int i = 0; i < TAPS; i++) begin
            rank_c[i] = '0;
            if (q_job.mask[i]) begin
                n_c = n_c + RANK_W'(1);
            end
            for (int j = 0; j < TAPS; j++) begin
                if ((j != i) && q_job.mask[j] &&
                    ((q_job.vals[j] < q_job.vals[i]) ||
                     ((q_job.vals[j] == q_job.vals[i]) && (j < i)))) begin
                    rank_c[i] = rank_c[i] + RANK_W'(1);
                end
            end
        end
    end

    // Pick the two middle ranks; for an odd count both are the same tap.
    assign lo_k = (s1_n_reg - RANK_W'(1)) >> 1;
    assign hi_k = s1_n_reg >> 1;
    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < TAPS; i++) begin
            lo_match[i] = s1_mask_reg[i] && (s1_rank_reg[i] == lo_k);
            hi_match[i] = s1_mask_reg[i] && (s1_rank_reg[i] == hi_k);
            lo_val = lo_val | (lo_match[i] ? s1_vals_reg[i] : '0);
            hi_val = hi_val | (hi_match[i] ? s1_vals_reg[i] : '0);
        end
        mid_sum = {1'b0, lo_val} + {1'b0, hi_val};
        filt_c  = (s1_n_reg == '0) ? '0 : mid_sum[PIX_W:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_vals_reg <= q_job.vals;
            s1_mask_reg <= q_job.mask;
            s1_fl_reg   <= q_job.frame_last;
            s1_rank_reg <= rank_c;
            s1_n_reg    <= n_c;
        end
        if (s1_adv) begin
            m_data_reg.filtered   <= filt_c;
            m_data_reg.frame_last <= s1_fl_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Ranks among valid taps are distinct, so at most one tap matches each.
    a_lo_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $onehot0(lo_match))
        else $error("two taps share the lower middle rank");

    a_hi_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $onehot0(hi_match))
        else $error("two taps share the upper middle rank");

endmodule

// ----- src/median_filter_3x3_window.sv -----
// Channel  | Ports                           | Direction | Word
// ---------+---------------------------------+-----------+---------------------------
// input    | s_valid, s_ready, s_data        | in        | func, pixel
// result   | m_valid, m_ready, m_data        | out       | filtered, frame_last
// config   | psel, penable, pwrite, paddr,   | in/out    | image_width at 0x0,
//          | pwdata, prdata, pready          |           | image_height at 0x4
//
// One input word is taken every cycle while the result side keeps up.
// A result becomes valid once the word completing its neighborhood has gone through the
// bank read on the edge that accepts it, then queue write, rank, and select and average.
// s_ready stays high while the four-entry queue has room for every word in flight.
// Reset clears all counters and the queue; the row banks are not cleared.
// When the result side stalls, the queue fills and s_ready drops.
module median_filter_3x3_window #(
    parameter int MAX_WIDTH = mf3w_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mf3w_pkg::in_word_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mf3w_pkg::out_word_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mf3w_pkg::ADDR_W-1:0]   paddr,
    input  logic [mf3w_pkg::DATA_W-1:0]   pwdata,
    output logic [mf3w_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    mf3w_pkg::cfg_t                cfg_reg;
    logic                          cfg_wr;
    logic                          push_valid;
    mf3w_pkg::job_t                push_job;
    logic                          pop;
    logic                          q_valid;
    mf3w_pkg::job_t                q_job;
    logic [mf3w_pkg::QLVL_W-1:0]   q_level;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= mf3w_pkg::IMAGE_WIDTH_RESET;
            cfg_reg.image_height <= mf3w_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                mf3w_pkg::REG_IMAGE_WIDTH: begin
                    cfg_reg.image_width <= pwdata[mf3w_pkg::CFGW_W-1:0];
                end
                mf3w_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_reg.image_height <= pwdata[mf3w_pkg::CFGH_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mf3w_pkg::REG_IMAGE_WIDTH: begin
                prdata = mf3w_pkg::DATA_W'(cfg_reg.image_width);
            end
            mf3w_pkg::REG_IMAGE_HEIGHT: begin
                prdata = mf3w_pkg::DATA_W'(cfg_reg.image_height);
            end
        endcase
    end

    // Front: line banks, counters and neighborhood gathering.
    mf3w_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .s_ready    (s_ready),
        .q_level    (q_level),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    // Queue between gathering and the median unit.
    mf3w_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .q_level    (q_level)
    );

    // Back: ranking, median selection and the output register.
    mf3w_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
